/* rtl/range_max_sum_tree_with_offset_top_assert.svh */
// assertion macros shared by the checker of range_max_sum_tree_with_offset_top
// no dependencies; include by bare file name
`ifndef RANGE_MAX_SUM_TREE_WITH_OFFSET_TOP_ASSERT_SVH
`define RANGE_MAX_SUM_TREE_WITH_OFFSET_TOP_ASSERT_SVH

// same-cycle implication under reset
`define RMST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("rmst check failed: same-cycle implication");

// next-cycle implication under reset
`define RMST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("rmst check failed: next-cycle implication");

`endif

/* rtl/rmst_pkg.sv */
// shared types and constants for the range max / sum tree block
// no dependencies
package rmst_pkg;

	localparam int LEAVES_DEF = 131072;
	localparam int IDX_W      = 17;
	localparam int VALUE_W    = 32;
	localparam int OFFSET_W   = 40;
	localparam int ANS_W      = 63;
	localparam int OP_W       = 2;

	localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
	localparam logic [OP_W-1:0] OP_MAX  = 2'd1;
	localparam logic [OP_W-1:0] OP_SUM  = 2'd2;
	localparam logic [OP_W-1:0] OP_ADD  = 2'd3;

	typedef struct packed {
		logic clr_step;
		logic start;
		logic add;
		logic leaf_wr;
		logic up_rd;
		logic up_wr;
		logic walk_init;
		logic walk_rd;
		logic walk_acc;
		logic mul;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic is_load;
		logic is_add;
		logic load_ok;
		logic bad;
		logic up_last;
		logic walk_done;
	} dp_sts_t;

endpackage

/* rtl/rmst_ctrl.sv */
// controller state machine of the range max / sum tree block
// depends on rmst_pkg
module rmst_ctrl
	import rmst_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	output logic    m_tvalid,
	input  logic    m_tready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	localparam logic [3:0] ST_CLEAR    = 4'd0;
	localparam logic [3:0] ST_IDLE     = 4'd1;
	localparam logic [3:0] ST_DECODE   = 4'd2;
	localparam logic [3:0] ST_UP_RD    = 4'd3;
	localparam logic [3:0] ST_UP_WR    = 4'd4;
	localparam logic [3:0] ST_WALK_RD  = 4'd5;
	localparam logic [3:0] ST_WALK_ACC = 4'd6;
	localparam logic [3:0] ST_MUL      = 4'd7;
	localparam logic [3:0] ST_FIN      = 4'd8;

	logic [3:0] state_q, state_d;
	logic       out_vld_q;
	logic       out_free;

	assign out_free = !out_vld_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_vld_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.start = 1'b1;
					state_d   = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (sts.is_add) begin
					cmd.add = 1'b1;
					state_d = ST_IDLE;
				end else if (sts.is_load) begin
					if (sts.load_ok) begin
						cmd.leaf_wr = 1'b1;
						state_d     = ST_UP_RD;
					end else begin
						state_d = ST_IDLE;
					end
				end else if (sts.bad) begin
					state_d = ST_FIN;
				end else begin
					cmd.walk_init = 1'b1;
					state_d       = ST_WALK_RD;
				end
			end
			ST_UP_RD: begin
				cmd.up_rd = 1'b1;
				state_d   = ST_UP_WR;
			end
			ST_UP_WR: begin
				cmd.up_wr = 1'b1;
				state_d   = sts.up_last ? ST_IDLE : ST_UP_RD;
			end
			ST_WALK_RD: begin
				if (sts.walk_done) begin
					state_d = ST_MUL;
				end else begin
					cmd.walk_rd = 1'b1;
					state_d     = ST_WALK_ACC;
				end
			end
			ST_WALK_ACC: begin
				cmd.walk_acc = 1'b1;
				state_d      = ST_WALK_RD;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/rmst_dp.sv */
// datapath of the range max / sum tree block: node memory, walk, offset, answer
// depends on rmst_pkg
module rmst_dp
	import rmst_pkg::*;
#(
	parameter int LEAVES = LEAVES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	output dp_sts_t             sts,
	input  logic [OP_W-1:0]     opcode,
	input  logic [IDX_W-1:0]    left_index,
	input  logic [IDX_W-1:0]    right_index,
	input  logic [VALUE_W-1:0]  value,
	input  logic                cfg_wr_en,
	input  logic [IDX_W-1:0]    cfg_wr_data,
	output logic                query_kind,
	output logic [ANS_W-1:0]    answer,
	output logic                range_error
);

	localparam int TREE_NODES = 2 * LEAVES;
	localparam int LOG2L      = $clog2(LEAVES);
	localparam int NW         = LOG2L + 1;
	localparam int SW         = VALUE_W + LOG2L;
	localparam int EW         = SW + VALUE_W;
	localparam int CW         = NW + IDX_W + 1;
	localparam int PW         = IDX_W + OFFSET_W;
	localparam logic [CW-1:0] LIM   = CW'(LEAVES - 2);
	localparam logic [NW-1:0] LBASE = NW'(LEAVES);

	// entry layout: sum in the upper bits, maximum in the lower bits
	logic [EW-1:0] mem_q [TREE_NODES];
	logic [EW-1:0] rd_a_q, rd_b_q;
	logic [NW-1:0] rd_addr_a, rd_addr_b, wr_addr;
	logic [EW-1:0] wr_data;
	logic          wr_en;

	logic [OP_W-1:0]     op_q;
	logic [IDX_W-1:0]    left_q, right_q, n_q;
	logic [VALUE_W-1:0]  val_q;
	logic [OFFSET_W-1:0] off_q;
	logic [NW-1:0]       clr_addr_q, node_q, lo_q, hi_q;
	logic                tlo_q, thi_q;
	logic [SW-1:0]       acc_q;
	logic [PW-1:0]       prod_q;

	logic                out_kind_q, out_err_q;
	logic [ANS_W-1:0]    out_ans_q;

	logic [NW-1:0]       leaf;
	logic [SW-1:0]       sa, sb, sum_ab;
	logic [VALUE_W-1:0]  ma, mb, max_ab, acc_m, m_lo, m_hi, m_walk;
	logic [OFFSET_W:0]   off_sum;
	logic [IDX_W-1:0]    len;
	logic [63:0]         ans_sum, ans_max;
	logic                is_sum;

	assign sa     = rd_a_q[EW-1:VALUE_W];
	assign sb     = rd_b_q[EW-1:VALUE_W];
	assign ma     = rd_a_q[VALUE_W-1:0];
	assign mb     = rd_b_q[VALUE_W-1:0];
	assign sum_ab = sa + sb;
	assign max_ab = (ma > mb) ? ma : mb;
	assign leaf   = LBASE + NW'(left_q);
	assign is_sum = (op_q == OP_SUM);

	assign sts.clr_done  = (clr_addr_q == NW'(TREE_NODES - 1));
	assign sts.is_load   = (op_q == OP_LOAD);
	assign sts.is_add    = (op_q == OP_ADD);
	assign sts.load_ok   = (left_q != '0) && (CW'(left_q) <= LIM);
	assign sts.bad       = (left_q == '0) || (left_q > right_q) ||
		(right_q > n_q) || (CW'(right_q) > LIM);
	assign sts.up_last   = (node_q == NW'(1));
	assign sts.walk_done = ((lo_q ^ hi_q ^ NW'(1)) == '0) || (lo_q == '0) || (hi_q == '0);

	// write port select
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = clr_addr_q;
		wr_data = '0;
		priority if (cmd.clr_step) begin
			wr_en = 1'b1;
		end else if (cmd.leaf_wr) begin
			wr_en   = 1'b1;
			wr_addr = leaf;
			wr_data = {SW'(val_q), val_q};
		end else if (cmd.up_wr) begin
			wr_en   = 1'b1;
			wr_addr = node_q;
			wr_data = {sum_ab, max_ab};
		end
	end

	always_comb begin
		if (cmd.up_rd) begin
			rd_addr_a = {node_q[NW-2:0], 1'b0};
			rd_addr_b = {node_q[NW-2:0], 1'b1};
		end else begin
			rd_addr_a = lo_q ^ NW'(1);
			rd_addr_b = hi_q ^ NW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		rd_a_q <= mem_q[rd_addr_a];
		rd_b_q <= mem_q[rd_addr_b];
	end

	// walk accumulation, both sides of the open interval in one step
	assign acc_m  = acc_q[VALUE_W-1:0];
	assign m_lo   = tlo_q ? ma : '0;
	assign m_hi   = thi_q ? mb : '0;
	assign m_walk = (m_lo > m_hi) ? m_lo : m_hi;

	assign off_sum = {1'b0, off_q} + (OFFSET_W+1)'(val_q);
	assign len     = right_q - left_q + IDX_W'(1);
	assign ans_sum = 64'(acc_q) + 64'(prod_q);
	assign ans_max = 64'(acc_q) + 64'(off_q);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q    <= opcode;
			left_q  <= left_index;
			right_q <= right_index;
			val_q   <= value;
		end
		if (cmd.leaf_wr) begin
			node_q <= leaf >> 1;
		end else if (cmd.up_wr) begin
			node_q <= node_q >> 1;
		end
		if (cmd.walk_init) begin
			lo_q  <= LBASE + NW'(left_q) - NW'(1);
			hi_q  <= LBASE + NW'(right_q) + NW'(1);
			acc_q <= '0;
		end else if (cmd.walk_acc) begin
			lo_q <= lo_q >> 1;
			hi_q <= hi_q >> 1;
			if (is_sum) begin
				acc_q <= acc_q + (tlo_q ? sa : '0) + (thi_q ? sb : '0);
			end else if (m_walk > acc_m) begin
				acc_q <= SW'(m_walk);
			end
		end
		if (cmd.walk_rd) begin
			tlo_q <= ~lo_q[0];
			thi_q <= hi_q[0];
		end
		if (cmd.mul) prod_q <= PW'(len) * PW'(off_q);
		if (cmd.out_load) begin
			out_kind_q <= is_sum;
			out_err_q  <= sts.bad;
			if (sts.bad) begin
				out_ans_q <= '0;
			end else if (is_sum) begin
				out_ans_q <= ans_sum[ANS_W-1:0];
			end else begin
				out_ans_q <= ans_max[ANS_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			off_q      <= '0;
			n_q        <= IDX_W'(1);
		end else begin
			if (cmd.clr_step) clr_addr_q <= clr_addr_q + NW'(1);
			if (cmd.add) off_q <= off_sum[OFFSET_W] ? '1 : off_sum[OFFSET_W-1:0];
			if (cfg_wr_en) n_q <= cfg_wr_data;
		end
	end

	assign query_kind  = out_kind_q;
	assign answer      = out_ans_q;
	assign range_error = out_err_q;

endmodule

/* rtl/range_max_sum_tree_with_offset_top.sv */
// top level of the range max / sum tree block: controller plus datapath
// depends on rmst_pkg, rmst_ctrl, rmst_dp
//
// Keeps a bottom-up binary tree of node sums and maxima over LEAVES leaves in a
// two-read, one-write memory of 2*LEAVES entries, plus a saturating 40-bit offset.
// After reset the block sweeps the memory to zero, one entry per cycle, with
// s_tready low; cfg writes are taken throughout. An offset add is applied in the
// decode step. A load writes its leaf there, then climbs to the root with a
// memory read step and an update step for each tree level. A query walks up the
// tree with a read step and an accumulate step per level, then multiplies and
// loads the output register; a query with a bad range goes straight to that step.
// A query waits in its last step while an older answer is still held in the output
// register. One item is worked on at a time. A finished answer waits in the output
// register while the next item is accepted; only queries produce a transaction.
module range_max_sum_tree_with_offset_top
	import rmst_pkg::*;
#(
	parameter int LEAVES = LEAVES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [OP_W-1:0]    s_tuser,   // opcode[1:0]
	input  logic [71:0]        s_tdata,   // left_index[16:0], right_index[33:17], value[65:34]
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [1:0]         m_tuser,   // query_kind[0], range_error[1]
	output logic [63:0]        m_tdata,   // answer[62:0]
	input  logic               cfg_wr_en,
	input  logic [IDX_W-1:0]   cfg_wr_data
);

	dp_cmd_t          cmd;
	dp_sts_t          sts;
	logic             query_kind, range_error;
	logic [ANS_W-1:0] answer;

	rmst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rmst_dp #(
		.LEAVES (LEAVES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.opcode      (s_tuser),
		.left_index  (s_tdata[16:0]),
		.right_index (s_tdata[33:17]),
		.value       (s_tdata[65:34]),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.query_kind  (query_kind),
		.answer      (answer),
		.range_error (range_error)
	);

	assign m_tuser = {range_error, query_kind};
	assign m_tdata = {1'b0, answer};

endmodule

/* rtl/rmst_checker.sv */
// port-level checker for range_max_sum_tree_with_offset_top, bound to the top level
// depends on rmst_pkg and range_max_sum_tree_with_offset_top_assert.svh
`include "range_max_sum_tree_with_offset_top_assert.svh"

module rmst_checker
	import rmst_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               s_tvalid,
	input logic               s_tready,
	input logic [OP_W-1:0]    s_tuser,
	input logic [71:0]        s_tdata,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [1:0]         m_tuser,
	input logic [63:0]        m_tdata,
	input logic               cfg_wr_en,
	input logic [IDX_W-1:0]   cfg_wr_data
);

	// a pending result transaction is not withdrawn
	`RMST_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	// one item at a time: busy right after an accepted transaction
	`RMST_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready)
	// a bad range answers zero
	`RMST_ASSERT_NOW(a_err_zero, clk, arst_n, m_tvalid && m_tuser[1], m_tdata == 64'd0)
	// max answer is at most a 32-bit value plus a 40-bit offset
	`RMST_ASSERT_NOW(a_max_width, clk, arst_n, m_tvalid && !m_tuser[0], m_tdata[63:41] == '0)
	`RMST_ASSERT_NOW(a_top_bit, clk, arst_n, m_tvalid, !m_tdata[63])

endmodule

bind range_max_sum_tree_with_offset_top rmst_checker u_rmst_checker (.*);

/* verif/range_max_sum_tree_with_offset_top_tb.sv */
// testbench for range_max_sum_tree_with_offset_top: directed table, then random phases
// depends on rmst_pkg and the rtl of the block; checks answers against an in-bench tree model
`timescale 1ns / 100ps

module range_max_sum_tree_with_offset_top_tb;
	import rmst_pkg::*;

	localparam int LEAVES     = LEAVES_DEF;
	localparam int NODES      = 2 * LEAVES;
	localparam int IDX_TOP    = LEAVES - 2;
	localparam int SETTLE_CYC = 60;

	typedef struct packed {
		bit        kind;
		bit [62:0] answer;
		bit        err;
	} answer_t;

	typedef struct {
		bit              is_cfg;
		logic [OP_W-1:0] op;
		bit [16:0]       lft;
		bit [16:0]       rgt;
		bit [31:0]       val;
		bit              typed;
		answer_t         want;
	} row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [OP_W-1:0]    s_tuser = OP_LOAD;
	logic [71:0]        s_tdata = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [1:0]         m_tuser;
	logic [63:0]        m_tdata;
	logic               cfg_wr_en = 1'b0;
	logic [IDX_W-1:0]   cfg_wr_data = '0;

	// tree model state
	bit [48:0] tree_sum [0:NODES-1];
	bit [31:0] tree_max [0:NODES-1];
	bit [39:0] offset_acc;
	int unsigned elem_count = 1;

	answer_t answer_q[$];
	int unsigned mismatches;
	bit offering;
	int unsigned burst_left;
	bit long_hold_req;
	row_t dir_tab[$];

	range_max_sum_tree_with_offset_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tuser    (s_tuser),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tuser    (m_tuser),
		.m_tdata    (m_tdata),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #1 clk = ~clk;

	function automatic void store_leaf(int unsigned idx, bit [31:0] v);
		int unsigned k;
		k = LEAVES + idx;
		tree_sum[k] = 49'(v);
		tree_max[k] = v;
		k = k >> 1;
		while (k >= 1) begin
			tree_sum[k] = tree_sum[2*k] + tree_sum[2*k+1];
			tree_max[k] = (tree_max[2*k] > tree_max[2*k+1]) ? tree_max[2*k] : tree_max[2*k+1];
			k = k >> 1;
		end
	endfunction

	// bottom-up walk over the open interval around [l, r]
	function automatic bit [63:0] tree_range(int unsigned l, int unsigned r, bit want_sum);
		int unsigned lo, hi;
		bit [63:0] acc;
		lo = LEAVES + l - 1;
		hi = LEAVES + r + 1;
		acc = 0;
		while (((lo ^ hi ^ 1) != 0) && lo != 0 && hi != 0) begin
			if ((lo & 1) == 0) begin
				if (want_sum) acc += 64'(tree_sum[lo ^ 1]);
				else if (tree_max[lo ^ 1] > acc) acc = 64'(tree_max[lo ^ 1]);
			end
			if ((hi & 1) != 0) begin
				if (want_sum) acc += 64'(tree_sum[hi ^ 1]);
				else if (tree_max[hi ^ 1] > acc) acc = 64'(tree_max[hi ^ 1]);
			end
			lo = lo >> 1;
			hi = hi >> 1;
		end
		return acc;
	endfunction

	function automatic bit apply_item(logic [OP_W-1:0] op, bit [16:0] l, bit [16:0] r,
			bit [31:0] v, output answer_t res);
		bit [40:0] t;
		bit bad;
		bit [63:0] ans;
		res = '0;
		case (op)
			OP_LOAD: begin
				if (l >= 1 && l <= IDX_TOP) store_leaf(l, v);
				return 1'b0;
			end
			OP_ADD: begin
				t = offset_acc + v;
				offset_acc = t[40] ? '1 : t[39:0];
				return 1'b0;
			end
			default: begin
				bad = l < 1 || l > r || r > elem_count || r > IDX_TOP;
				ans = 0;
				if (!bad) begin
					if (op == OP_SUM)
						ans = tree_range(l, r, 1'b1) + 64'(r - l + 1) * 64'(offset_acc);
					else
						ans = tree_range(l, r, 1'b0) + 64'(offset_acc);
				end
				res.kind = (op == OP_SUM);
				res.answer = ans[62:0];
				res.err = bad;
				return 1'b1;
			end
		endcase
	endfunction

	task automatic send_item(logic [OP_W-1:0] op, bit [16:0] l, bit [16:0] r, bit [31:0] v,
			bit typed, answer_t want);
		answer_t pred;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {6'b0, v, r, l};
		offering = 1'b1;
		do @(posedge clk); while (!s_tready);
		if (apply_item(op, l, r, v, pred))
			answer_q.push_back(typed ? want : pred);
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			offering = 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 10);
		end
	endtask

	task automatic wait_drained();
		if (offering) begin
			s_tvalid <= 1'b0;
			offering = 1'b0;
		end
		while (answer_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_limit(bit [16:0] n);
		wait_drained();
		repeat (SETTLE_CYC) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= n;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		elem_count = 32'(n);
	endtask

	function automatic void add_row(bit is_cfg, logic [OP_W-1:0] op, bit [16:0] l,
			bit [16:0] r, bit [31:0] v, bit typed, bit kind, bit [62:0] ans, bit err);
		row_t w;
		w.is_cfg = is_cfg;
		w.op = op;
		w.lft = l;
		w.rgt = r;
		w.val = v;
		w.typed = typed;
		w.want = '{kind, ans, err};
		dir_tab.push_back(w);
	endfunction

	task automatic random_item(int unsigned n);
		logic [OP_W-1:0] op;
		bit [16:0] l, r;
		bit [31:0] v;
		int unsigned sel, span, top;
		sel = $urandom_range(0, 99);
		l = 17'($urandom);
		r = 17'($urandom);
		v = $urandom;
		if (sel < 30) begin
			op = OP_LOAD;
			top = (n + 2 > IDX_TOP) ? IDX_TOP : n + 2;
			if ($urandom_range(0, 19) != 0) l = 17'($urandom_range(1, top));
			case ($urandom_range(0, 3))
				0: v = 0;
				1: v = '1;
				2: v = $urandom_range(0, 255);
				default: ;
			endcase
		end else if (sel < 82) begin
			op = $urandom_range(0, 1) ? OP_SUM : OP_MAX;
			if ($urandom_range(0, 9) != 0) begin
				l = 17'($urandom_range(1, n));
				span = $urandom_range(0, 3) == 0 ? n : $urandom_range(0, 8);
				top = (l + span > n) ? n : l + span;
				r = 17'($urandom_range(l, top));
			end
		end else begin
			op = OP_ADD;
			if ($urandom_range(0, 3) != 0) v = $urandom_range(0, 1000);
		end
		send_item(op, l, r, v, 1'b0, '0);
	endtask

	// receiver: stall pattern is redrawn from four modes, with one long hold on request
	initial begin
		int unsigned mode, cyc;
		cyc = 0;
		mode = 0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				m_tready <= 1'b0;
				repeat (3000) @(posedge clk);
				long_hold_req = 1'b0;
			end else begin
				if (cyc % 64 == 0) mode = $urandom_range(0, 3);
				cyc++;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 3) != 0);
					default: m_tready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	// compare every result transaction with the oldest expected answer
	always @(posedge clk) begin
		answer_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tuser[0], m_tdata[62:0], m_tuser[1]};
			if (answer_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: kind %0d answer %0h err %0d",
						got.kind, got.answer, got.err);
			end else begin
				want = answer_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp kind %0d answer %0h err %0d, got kind %0d answer %0h err %0d",
							want.kind, want.answer, want.err, got.kind, got.answer, got.err);
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int unsigned limits[6];
		int unsigned wait_cyc;
		burst_left = 5;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// after reset: element count is 1 and the tree is all zero
		add_row(0, OP_MAX,  1, 1, 0, 1, 0, 0, 0);
		add_row(0, OP_SUM,  1, 1, 0, 1, 1, 0, 0);
		add_row(0, OP_MAX,  0, 1, 0, 1, 0, 0, 1);
		add_row(0, OP_SUM,  2, 1, 0, 1, 1, 0, 1);
		add_row(0, OP_MAX,  1, 2, 0, 1, 0, 0, 1);
		add_row(0, OP_LOAD, 1, 0, 32'hffff_ffff, 0, 0, 0, 0);
		add_row(0, OP_MAX,  1, 1, 0, 1, 0, 63'hffff_ffff, 0);
		add_row(0, OP_SUM,  1, 1, 0, 1, 1, 63'hffff_ffff, 0);
		// loads outside the leaf range are dropped, one past the count is kept
		add_row(0, OP_LOAD, 0, 0, 5, 0, 0, 0, 0);
		add_row(0, OP_LOAD, 17'h1ffff, 17'h1ffff, 7, 0, 0, 0, 0);
		add_row(0, OP_LOAD, IDX_TOP, 0, 9, 0, 0, 0, 0);
		add_row(0, OP_LOAD, 2, 0, 3, 0, 0, 0, 0);
		add_row(0, OP_ADD,  0, 0, 32'hffff_ffff, 0, 0, 0, 0);
		add_row(0, OP_MAX,  1, 1, 0, 1, 0, 63'h1_ffff_fffe, 0);
		add_row(0, OP_SUM,  1, 1, 0, 1, 1, 63'h1_ffff_fffe, 0);
		add_row(0, OP_MAX,  17'h1ffff, 17'h1ffff, 0, 1, 0, 0, 1);
		add_row(0, OP_SUM,  1, 17'h1ffff, 0, 1, 1, 0, 1);
		add_row(1, OP_LOAD, 0, 0, IDX_TOP, 0, 0, 0, 0);
		add_row(0, OP_MAX,  IDX_TOP, IDX_TOP, 0, 0, 0, 0, 0);
		add_row(0, OP_SUM,  1, IDX_TOP, 0, 0, 0, 0, 0);
		add_row(0, OP_MAX,  1, IDX_TOP, 0, 0, 0, 0, 0);
		add_row(0, OP_SUM,  1, 2, 0, 0, 0, 0, 0);
		add_row(0, OP_SUM,  IDX_TOP, IDX_TOP + 1, 0, 1, 1, 0, 1);
		add_row(0, OP_ADD,  0, 0, 0, 0, 0, 0, 0);
		add_row(0, OP_MAX,  2, 2, 0, 0, 0, 0, 0);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg)
				write_limit(dir_tab[i].val[16:0]);
			else
				send_item(dir_tab[i].op, dir_tab[i].lft, dir_tab[i].rgt, dir_tab[i].val,
					dir_tab[i].typed, dir_tab[i].want);
		end

		limits = '{16, 3, 131070, 1000, 1, $urandom_range(1, 131070)};
		foreach (limits[p]) begin
			write_limit(17'(limits[p]));
			if (p == 2) long_hold_req = 1'b1;
			for (int i = 0; i < 260; i++) begin
				// one pause until all answers are back
				if (p == 1 && i == 150) wait_drained();
				random_item(limits[p]);
			end
		end

		// push the offset into saturation, then query around it
		for (int i = 0; i < 260; i++) begin
			send_item(OP_ADD, 17'($urandom), 17'($urandom), 32'hffff_ffff, 1'b0, '0);
			if (i % 20 == 0) random_item(elem_count);
		end
		for (int i = 0; i < 40; i++) random_item(elem_count);

		wait_drained();
		wait_cyc = 0;
		while (answer_q.size() != 0 && wait_cyc < 200000) begin
			@(posedge clk);
			wait_cyc++;
		end
		if (answer_q.size() != 0) mismatches++;
		repeat (SETTLE_CYC) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
